[rtl/dpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Document pixel recolor package
// Shared types, register map and link-detection constants.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned REG_IW   = 3;
    localparam int unsigned CCNT_W   = 3;

    // Register indexes (byte address is four times the index).
    typedef enum logic [REG_IW-1:0] {
        REG_TEXT_COLOR  = 3'd0,
        REG_BG_COLOR    = 3'd1,
        REG_LINK_COLOR  = 3'd2,
        REG_LINK_ENABLE = 3'd3,
        REG_CHAN_COUNT  = 3'd4
    } reg_idx_t;

    localparam logic [COLOR_W-1:0] TEXT_RESET = 24'h000000;
    localparam logic [COLOR_W-1:0] BG_RESET   = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] LINK_RESET = 24'h000000;
    localparam logic [CCNT_W-1:0]  CCNT_RESET = 3'd4;

    // Link detection thresholds. The mean test floor(sum/3) <= 230 is
    // the same as sum <= 3*230+2.
    localparam logic [9:0] LINK_MARGIN   = 10'd25;
    localparam logic [9:0] LINK_MIN_BLUE = 10'd72;
    localparam logic [9:0] LINK_MAX_SUM  = 10'd692;

    localparam logic [17:0] ROUND_BIAS = 18'sd128;
    localparam logic [8:0]  ALPHA_DIFF = 9'sd255;

    typedef struct packed {
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] link_color;
        logic               link_enable;
        logic [CCNT_W-1:0]  channel_count;
    } cfg_t;

endpackage

[rtl/dpr_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Document pixel recolor configuration registers
// APB register file holding the colors, link enable and channel count.
// ----------------------------------------------------------------------------
module dpr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpr_pkg::APB_AW-1:0]  paddr,
    input  logic [dpr_pkg::WORD_W-1:0]  pwdata,
    output logic [dpr_pkg::WORD_W-1:0]  prdata,
    output logic                        pready,
    output dpr_pkg::cfg_t               cfg
);
    import dpr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_color    <= TEXT_RESET;
            cfg_reg.bg_color      <= BG_RESET;
            cfg_reg.link_color    <= LINK_RESET;
            cfg_reg.link_enable   <= 1'b0;
            cfg_reg.channel_count <= CCNT_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_TEXT_COLOR:  cfg_reg.text_color    <= pwdata[COLOR_W-1:0];
                REG_BG_COLOR:    cfg_reg.bg_color      <= pwdata[COLOR_W-1:0];
                REG_LINK_COLOR:  cfg_reg.link_color    <= pwdata[COLOR_W-1:0];
                REG_LINK_ENABLE: cfg_reg.link_enable   <= pwdata[0];
                REG_CHAN_COUNT:  cfg_reg.channel_count <= pwdata[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TEXT_COLOR:  prdata = {8'd0, cfg_reg.text_color};
            REG_BG_COLOR:    prdata = {8'd0, cfg_reg.bg_color};
            REG_LINK_COLOR:  prdata = {8'd0, cfg_reg.link_color};
            REG_LINK_ENABLE: prdata = {31'd0, cfg_reg.link_enable};
            REG_CHAN_COUNT:  prdata = {29'd0, cfg_reg.channel_count};
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/dpr_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Document pixel recolor channel
// Computes base + round(x * diff / 255), truncated to one byte.
// ----------------------------------------------------------------------------
module dpr_chan (
    input  logic [dpr_pkg::PIX_W-1:0]  x,
    input  logic [dpr_pkg::PIX_W-1:0]  base,
    input  logic signed [8:0]          diff,
    output logic [dpr_pkg::PIX_W-1:0]  result
);
    import dpr_pkg::*;

    logic signed [17:0] x_ext;
    logic signed [17:0] d_ext;
    logic signed [17:0] prod;
    logic signed [17:0] n;
    logic signed [17:0] n_adj;

    assign x_ext = $signed({10'd0, x});
    assign d_ext = $signed({{9{diff[8]}}, diff});
    assign prod  = 18'(x_ext * d_ext);
    assign n     = prod + $signed(ROUND_BIAS);
    assign n_adj = n + (n >>> 8);

    // Only the low byte of the shifted value survives the final truncation.
    assign result = base + n_adj[15:8];

endmodule

[rtl/document_pixel_recolor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Document pixel recolor
// Maps page pixels onto a text/background palette with optional link tint.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel, one word per B,G,R,A pixel, with tuser
//   marking a pass-through pixel that is returned unchanged. Results leave
//   on the m_ channel in the same order, one word per input word.
//   Colors, link enable and channel count are set through the APB port and
//   should only be written while no pixel is in flight.
// Datapath and throughput:
//   A word is captured in the input register, recolored by one multiplier
//   per channel, and lands in the output register. One word is accepted
//   every cycle while m_tready stays high.
// Reset:
//   aresetn clears both pipeline stages and loads the register defaults.
// Stall:
//   When m_tready is low the output holds; the input register still takes
//   one more word if it is empty, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module document_pixel_recolor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // in_blue, in_green, in_red, in_alpha
    input  logic                        s_tuser,   // pass_through
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // out_blue, out_green, out_red, out_alpha
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpr_pkg::APB_AW-1:0]  paddr,
    input  logic [dpr_pkg::WORD_W-1:0]  pwdata,
    output logic [dpr_pkg::WORD_W-1:0]  prdata,
    output logic                        pready
);
    import dpr_pkg::*;

    cfg_t        cfg;
    logic        s1_valid_reg;
    logic [31:0] s1_pix_reg;
    logic        s1_pass_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        s1_adv;
    logic        s_acc;

    logic [PIX_W-1:0] b, g, r, a;
    logic [9:0]       b_ext, maxrg, sum;
    logic [8:0]       rg_sum;
    logic             is_link;
    logic [CCNT_W-1:0] nch;
    logic [PIX_W-1:0] ch_x    [4];
    logic [PIX_W-1:0] ch_base [4];
    logic signed [8:0] ch_diff [4];
    logic [PIX_W-1:0] ch_res  [4];
    logic [PIX_W-1:0] px      [4];
    logic [31:0]      result;

    dpr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The input stage moves when the output register is empty or draining.
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pix_reg  <= s_tdata;
            s1_pass_reg <= s_tuser;
        end
        if (s1_adv && s1_valid_reg) begin
            m_data_reg <= result;
        end
    end

    assign b = s1_pix_reg[7:0];
    assign g = s1_pix_reg[15:8];
    assign r = s1_pix_reg[23:16];
    assign a = s1_pix_reg[31:24];
    assign px[0] = b;
    assign px[1] = g;
    assign px[2] = r;
    assign px[3] = a;

    assign b_ext  = {2'd0, b};
    assign maxrg  = (r > g) ? {2'd0, r} : {2'd0, g};
    assign sum    = {2'd0, b} + {2'd0, g} + {2'd0, r};
    assign rg_sum = {1'b0, g} + {1'b0, r};
    assign is_link = cfg.link_enable && (b_ext >= maxrg + LINK_MARGIN)
                  && (b_ext >= LINK_MIN_BLUE) && (sum <= LINK_MAX_SUM);
    assign nch = (cfg.channel_count > CCNT_RESET) ? CCNT_RESET : cfg.channel_count;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (is_link) begin
                ch_x[i]    = rg_sum[8:1];
                ch_base[i] = cfg.link_color[8*i +: 8];
                ch_diff[i] = $signed({1'b0, cfg.bg_color[8*i +: 8]})
                           - $signed({1'b0, cfg.link_color[8*i +: 8]});
            end else begin
                ch_x[i]    = px[i];
                ch_base[i] = cfg.text_color[8*i +: 8];
                ch_diff[i] = $signed({1'b0, cfg.bg_color[8*i +: 8]})
                           - $signed({1'b0, cfg.text_color[8*i +: 8]});
            end
        end
        ch_x[3]    = a;
        ch_base[3] = '0;
        ch_diff[3] = $signed(ALPHA_DIFF);
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_chan
        dpr_chan u_chan (
            .x      (ch_x[gi]),
            .base   (ch_base[gi]),
            .diff   (ch_diff[gi]),
            .result (ch_res[gi])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (s1_pass_reg) begin
                result[8*i +: 8] = px[i];
            end else if (is_link) begin
                result[8*i +: 8] = (i < 3) ? ch_res[i] : px[i];
            end else if (CCNT_W'(i) < nch) begin
                result[8*i +: 8] = ch_res[i];
            end else begin
                result[8*i +: 8] = px[i];
            end
        end
    end

    a_out_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("output word appeared without a word in the input stage");

    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_adv && s1_pass_reg) |=> (m_tdata == $past(s1_pix_reg)))
        else $error("pass-through word was modified");

    a_alpha_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_adv && (cfg.channel_count < CCNT_RESET))
        |=> (m_tdata[31:24] == $past(s1_pix_reg[31:24])))
        else $error("alpha changed with fewer than four channels");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("input stage overwritten while output stalled");

endmodule
